### design/gha_pkg.sv
// Shared types and constants for the gradient histogram accumulator.
// No dependencies; imported by every module of the block.
package gha_pkg;

    localparam int BIN_COUNT_DEF  = 256;
    localparam int SLOT_LIMIT_DEF = 32;

    localparam int SUM_W  = 48;
    localparam int VAL_W  = 32;
    localparam int SLOT_W = 6;
    localparam int BIN_W  = 8;
    // bin * stride + slot fits in 15 bits for 8-bit bins and 6-bit strides
    localparam int PROD_W = 15;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic KIND_ACC  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        OUT_OK    = 2'd0,
        OUT_SKIP  = 2'd1,
        OUT_RANGE = 2'd2,
        OUT_SAT   = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [SUM_W-1:0] grad;
        logic [SUM_W-1:0] hess;
    } t_entry;

endpackage

### design/gha_table.sv
// Histogram table: one 96-bit synchronous memory, registered read port,
// plus the clearing sweep that zeroes it after reset. Uses gha_pkg.
module gha_table #(
    parameter int DEPTH  = gha_pkg::BIN_COUNT_DEF * gha_pkg::SLOT_LIMIT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  gha_pkg::t_entry     i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output gha_pkg::t_entry     o_rdata,
    output logic                o_busy
);
    import gha_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    t_entry              mem [DEPTH];
    t_entry              r_rdata;
    logic                r_clearing;
    logic [ADDR_W-1:0]   r_clr_addr;

    logic                we_eff;
    logic [ADDR_W-1:0]   waddr_eff;
    t_entry              wdata_eff;

    always_comb begin
        if (r_clearing) begin
            we_eff    = 1'b1;
            waddr_eff = r_clr_addr;
            wdata_eff = '0;
        end else begin
            we_eff    = i_we;
            waddr_eff = i_waddr;
            wdata_eff = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_eff) begin
            mem[waddr_eff] <= wdata_eff;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

### design/gradient_histogram_accumulator.sv
// Top level of the gradient histogram accumulator.
// Depends on gha_pkg and gha_table.
//
// Takes one item per cycle sustained while o_stall is low; o_stall is high during
// the table clear and while a pending result is held back by i_stall. An accepted
// item has its table read and input fields registered; the add and write-back load
// the output register when that stage advances. The entry written back in a cycle
// is forwarded to an item that reads the same entry in that cycle. After reset
// the table is zeroed by a sweep of BIN_COUNT * SLOT_LIMIT entries (8192 at the
// defaults), one entry a cycle, during which o_stall stays high; configuration
// writes are taken throughout. Sums are signed Q32.16 and saturate at the
// 48-bit limits.
module gradient_histogram_accumulator #(
    parameter int BIN_COUNT  = gha_pkg::BIN_COUNT_DEF,
    parameter int SLOT_LIMIT = gha_pkg::SLOT_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [gha_pkg::SLOT_W-1:0]   i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_kind,
    input  logic [gha_pkg::BIN_W-1:0]    i_bin_index,
    input  logic signed [gha_pkg::SLOT_W-1:0] i_slot_index,
    input  logic signed [gha_pkg::VAL_W-1:0]  i_grad_value,
    input  logic signed [gha_pkg::VAL_W-1:0]  i_hess_value,
    input  logic                         i_pass_end,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [gha_pkg::SUM_W-1:0]  o_grad_total,
    output logic signed [gha_pkg::SUM_W-1:0]  o_hess_total,
    output logic [1:0]                   o_outcome,
    output logic                         o_pass_done
);
    import gha_pkg::*;

    localparam int DEPTH  = BIN_COUNT * SLOT_LIMIT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CALC_W = (ADDR_W > PROD_W) ? ADDR_W : PROD_W;

    // configuration
    logic [SLOT_W-1:0]  r_slots;
    logic [SLOT_W-1:0]  stride;

    // input decode
    logic [CALC_W-1:0]  addr_calc;
    logic [ADDR_W-1:0]  in_addr;
    t_outcome           in_code;
    logic               accept;

    // read stage
    logic               r_s1_valid;
    logic               r_s1_kind;
    logic [ADDR_W-1:0]  r_s1_addr;
    t_outcome           r_s1_code;
    logic [VAL_W-1:0]   r_s1_grad;
    logic [VAL_W-1:0]   r_s1_hess;
    logic               r_s1_pend;
    logic               r_s1_hit;
    t_entry             r_fwd;
    logic               s1_adv;

    // table
    t_entry             rdata;
    logic               tbl_busy;
    t_entry             old_entry;
    t_entry             wr_data;
    logic               wr_en;

    // add and clamp
    logic [SUM_W:0]     g_sum;
    logic [SUM_W:0]     h_sum;
    logic               g_sat;
    logic               h_sat;
    logic [SUM_W-1:0]   g_new;
    logic [SUM_W-1:0]   h_new;

    // result
    logic [SUM_W-1:0]   n_grad_total;
    logic [SUM_W-1:0]   n_hess_total;
    t_outcome           n_outcome;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_grad_total;
    logic [SUM_W-1:0]   r_hess_total;
    t_outcome           r_outcome;
    logic               r_pass_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SLOT_W'(1);
        end else if (i_cfg_wr_en) begin
            r_slots <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_slots == '0) begin
            stride = SLOT_W'(1);
        end else if (int'(r_slots) > SLOT_LIMIT) begin
            stride = SLOT_W'(SLOT_LIMIT);
        end else begin
            stride = r_slots;
        end
    end

    assign addr_calc = CALC_W'(i_bin_index) * CALC_W'(stride)
                     + CALC_W'(i_slot_index[SLOT_W-2:0]);
    assign in_addr   = addr_calc[ADDR_W-1:0];

    always_comb begin
        if (i_slot_index[SLOT_W-1]) begin
            in_code = OUT_SKIP;
        end else if (({1'b0, i_slot_index[SLOT_W-2:0]} >= stride)
                  || ({1'b0, i_bin_index} >= (BIN_W+1)'(BIN_COUNT))) begin
            in_code = OUT_RANGE;
        end else begin
            in_code = OUT_OK;
        end
    end

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = tbl_busy || (r_s1_valid && !s1_adv);
    assign accept  = i_valid && !o_stall;

    assign wr_en = s1_adv && (r_s1_code == OUT_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= i_kind;
            r_s1_addr <= in_addr;
            r_s1_code <= in_code;
            r_s1_grad <= i_grad_value;
            r_s1_hess <= i_hess_value;
            r_s1_pend <= i_pass_end;
            // the table read below misses the write of this same cycle
            r_s1_hit  <= wr_en && (r_s1_addr == in_addr);
            r_fwd     <= wr_data;
        end
    end

    gha_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (rdata),
        .o_busy  (tbl_busy)
    );

    assign old_entry = r_s1_hit ? r_fwd : rdata;

    assign g_sum = {old_entry.grad[SUM_W-1], old_entry.grad}
                 + {{(SUM_W+1-VAL_W){r_s1_grad[VAL_W-1]}}, r_s1_grad};
    assign h_sum = {old_entry.hess[SUM_W-1], old_entry.hess}
                 + {{(SUM_W+1-VAL_W){r_s1_hess[VAL_W-1]}}, r_s1_hess};

    // overflow when the two top bits of the widened sum disagree
    assign g_sat = g_sum[SUM_W] ^ g_sum[SUM_W-1];
    assign h_sat = h_sum[SUM_W] ^ h_sum[SUM_W-1];
    assign g_new = g_sat ? (g_sum[SUM_W] ? SUM_MIN : SUM_MAX) : g_sum[SUM_W-1:0];
    assign h_new = h_sat ? (h_sum[SUM_W] ? SUM_MIN : SUM_MAX) : h_sum[SUM_W-1:0];

    always_comb begin
        wr_data      = '0;
        n_grad_total = '0;
        n_hess_total = '0;
        n_outcome    = r_s1_code;
        if (r_s1_code == OUT_OK) begin
            if (r_s1_kind == KIND_READ) begin
                n_grad_total = old_entry.grad;
                n_hess_total = old_entry.hess;
            end else begin
                wr_data.grad = g_new;
                wr_data.hess = h_new;
                n_grad_total = g_new;
                n_hess_total = h_new;
                n_outcome    = (g_sat || h_sat) ? OUT_SAT : OUT_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_grad_total <= n_grad_total;
            r_hess_total <= n_hess_total;
            r_outcome    <= n_outcome;
            r_pass_done  <= r_s1_pend;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_grad_total = r_grad_total;
    assign o_hess_total = r_hess_total;
    assign o_outcome    = r_outcome;
    assign o_pass_done  = r_pass_done;

endmodule

### design/gha_checker.sv
// Port-level checks for the gradient histogram accumulator, bound to the
// top level below. Depends on gha_pkg.
module gha_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_stall,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic [gha_pkg::SUM_W-1:0]    o_grad_total,
    input  logic [gha_pkg::SUM_W-1:0]    o_hess_total,
    input  logic [1:0]                   o_outcome,
    input  logic                         o_pass_done
);
    import gha_pkg::*;

    // a result held back by the consumer stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_grad_total)
            && $stable(o_hess_total) && $stable(o_outcome) && $stable(o_pass_done))
        else $error("result changed while stalled");

    // skipped and out-of-range items never carry table data
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_outcome == OUT_SKIP || o_outcome == OUT_RANGE)
            |-> o_grad_total == '0 && o_hess_total == '0)
        else $error("nonzero totals on a skipped item");

    // reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending right after reset");

    // the table clear holds off input right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> o_stall)
        else $error("input taken during table clear");

endmodule

bind gradient_histogram_accumulator gha_checker u_gha_checker (.*);

### verif/gradient_histogram_accumulator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gradient_histogram_accumulator: directed and random items
// checked against a scoreboard that keeps its own copy of the histogram sums.
// Depends on gha_pkg and the block RTL only.
module gradient_histogram_accumulator_tb;
    import gha_pkg::*;

    localparam int     TABLE_DEPTH  = BIN_COUNT_DEF * SLOT_LIMIT_DEF;
    localparam longint TOTAL_MAX    = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint TOTAL_MIN    = -TOTAL_MAX - 1;
    localparam int     LIMIT_CYCLES = 600_000;
    localparam int     HOLD_CYCLES  = 60;
    // back-to-back adds of the extreme values on one entry
    localparam int     PUMP_COUNT   = 40;

    localparam logic signed [VAL_W-1:0] VALUE_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VALUE_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct {
        logic                     kind;
        logic [BIN_W-1:0]         bin;
        logic signed [SLOT_W-1:0] slot;
        logic signed [VAL_W-1:0]  grad;
        logic signed [VAL_W-1:0]  hess;
        logic                     pass_end;
    } t_sample_item;

    typedef struct {
        logic [SUM_W-1:0] grad;
        logic [SUM_W-1:0] hess;
        logic [1:0]       outcome;
        logic             pass_done;
    } t_entry_totals;

    class t_bin_sum_tracker;
        longint            grad_sums[TABLE_DEPTH];
        longint            hess_sums[TABLE_DEPTH];
        logic [SLOT_W-1:0] slots_cfg;
        t_entry_totals     expected_totals[$];
        int                mismatches;

        function new();
            slots_cfg  = 1;
            mismatches = 0;
            foreach (grad_sums[i]) begin
                grad_sums[i] = 0;
                hess_sums[i] = 0;
            end
        endfunction

        function void set_slots(logic [SLOT_W-1:0] value);
            slots_cfg = value;
        endfunction

        // zero acts as one, anything above the slot limit is capped
        function int row_stride();
            if (slots_cfg == 0) return 1;
            if (slots_cfg > SLOT_LIMIT_DEF) return SLOT_LIMIT_DEF;
            return int'(slots_cfg);
        endfunction

        function longint clamp_add(longint a, longint b, inout bit hit);
            longint s;
            s = a + b;
            if (s > TOTAL_MAX) begin
                hit = 1'b1;
                return TOTAL_MAX;
            end
            if (s < TOTAL_MIN) begin
                hit = 1'b1;
                return TOTAL_MIN;
            end
            return s;
        endfunction

        function void note_sample(t_sample_item it);
            t_entry_totals want;
            int            stride;
            int            addr;
            bit            hit;
            longint        gt;
            longint        ht;
            stride         = row_stride();
            hit            = 1'b0;
            want.grad      = '0;
            want.hess      = '0;
            want.outcome   = OUT_OK;
            want.pass_done = it.pass_end;
            if (it.slot < 0) begin
                want.outcome = OUT_SKIP;
            end else if (int'(it.slot) >= stride || int'(it.bin) >= BIN_COUNT_DEF) begin
                want.outcome = OUT_RANGE;
            end else begin
                addr = int'(it.bin) * stride + int'(it.slot);
                if (it.kind == KIND_READ) begin
                    want.grad       = grad_sums[addr][SUM_W-1:0];
                    want.hess       = hess_sums[addr][SUM_W-1:0];
                    grad_sums[addr] = 0;
                    hess_sums[addr] = 0;
                end else begin
                    gt = clamp_add(grad_sums[addr], longint'(it.grad), hit);
                    ht = clamp_add(hess_sums[addr], longint'(it.hess), hit);
                    grad_sums[addr] = gt;
                    hess_sums[addr] = ht;
                    want.grad       = gt[SUM_W-1:0];
                    want.hess       = ht[SUM_W-1:0];
                    if (hit) want.outcome = OUT_SAT;
                end
            end
            expected_totals.push_back(want);
        endfunction

        function void flag(string what, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] act_v);
            mismatches++;
            $display("%0t: %s mismatch: expected 'h%0h, got 'h%0h",
                     $time, what, exp_v, act_v);
        endfunction

        function void check_totals(t_entry_totals got);
            t_entry_totals want;
            if (expected_totals.size() == 0) begin
                flag("result with no item pending, grad_total", '0, got.grad);
                return;
            end
            want = expected_totals.pop_front();
            if (got.grad !== want.grad) flag("grad_total", want.grad, got.grad);
            if (got.hess !== want.hess) flag("hess_total", want.hess, got.hess);
            if (got.outcome !== want.outcome)
                flag("outcome", SUM_W'(want.outcome), SUM_W'(got.outcome));
            if (got.pass_done !== want.pass_done)
                flag("pass_done", SUM_W'(want.pass_done), SUM_W'(got.pass_done));
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [SLOT_W-1:0]        i_cfg_wr_data;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_kind;
    logic [BIN_W-1:0]         i_bin_index;
    logic signed [SLOT_W-1:0] i_slot_index;
    logic signed [VAL_W-1:0]  i_grad_value;
    logic signed [VAL_W-1:0]  i_hess_value;
    logic                     i_pass_end;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [SUM_W-1:0]  o_grad_total;
    logic signed [SUM_W-1:0]  o_hess_total;
    logic [1:0]               o_outcome;
    logic                     o_pass_done;

    t_bin_sum_tracker tracker;
    bit               idle_on;
    bit               hold_request;

    gradient_histogram_accumulator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_bin_index   (i_bin_index),
        .i_slot_index  (i_slot_index),
        .i_grad_value  (i_grad_value),
        .i_hess_value  (i_hess_value),
        .i_pass_end    (i_pass_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_grad_total  (o_grad_total),
        .o_hess_total  (o_hess_total),
        .o_outcome     (o_outcome),
        .o_pass_done   (o_pass_done)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sample_item mk(logic kind, logic [BIN_W-1:0] bin,
                                        logic signed [SLOT_W-1:0] slot,
                                        logic signed [VAL_W-1:0] g,
                                        logic signed [VAL_W-1:0] h, logic pe);
        t_sample_item it;
        it.kind     = kind;
        it.bin      = bin;
        it.slot     = slot;
        it.grad     = g;
        it.hess     = h;
        it.pass_end = pe;
        return it;
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return VAL_W'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    // mostly in-range slots on a few hot bins so that entries build up and get read back
    function automatic t_sample_item random_sample();
        t_sample_item it;
        int           stride;
        int           pick;
        stride = tracker.row_stride();
        pick   = $urandom_range(0, 9);
        it.kind = ($urandom_range(0, 3) == 0) ? KIND_READ : KIND_ACC;
        it.bin  = ($urandom_range(0, 1) == 0) ? BIN_W'($urandom_range(0, 3)) : BIN_W'($urandom);
        if (pick < 4)
            it.slot = SLOT_W'($urandom_range(0, (stride > 2) ? 1 : stride - 1));
        else if (pick < 7)
            it.slot = SLOT_W'($urandom_range(0, stride - 1));
        else if (pick < 9)
            it.slot = SLOT_W'(-int'($urandom_range(1, 32)));
        else
            it.slot = SLOT_W'($urandom_range((stride < 31) ? stride : 31, 31));
        it.grad     = random_value();
        it.hess     = random_value();
        it.pass_end = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    task automatic send_sample(t_sample_item it);
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_kind       <= it.kind;
        i_bin_index  <= it.bin;
        i_slot_index <= it.slot;
        i_grad_value <= it.grad;
        i_hess_value <= it.hess;
        i_pass_end   <= it.pass_end;
        do @(posedge i_clk); while (o_stall);
        tracker.note_sample(it);
    endtask

    // valid low with junk on the payload
    task automatic idle_gap(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid      <= 1'b0;
            i_kind       <= 1'($urandom);
            i_bin_index  <= BIN_W'($urandom);
            i_grad_value <= $urandom;
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tracker.expected_totals.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_slots(logic [SLOT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        tracker.set_slots(value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random_phase(logic [SLOT_W-1:0] slots, int count, bit with_hold);
        drain_results();
        write_slots(slots);
        if (with_hold) hold_request = 1'b1;
        repeat (count) begin
            if (idle_on && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 7));
            send_sample(random_sample());
        end
    endtask

    initial begin : rx_stall
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : result_check
        t_entry_totals got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.grad      = o_grad_total;
                got.hess      = o_hess_total;
                got.outcome   = o_outcome;
                got.pass_done = o_pass_done;
                tracker.check_totals(got);
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        tracker       = new();
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_valid       <= 1'b0;
        i_kind        <= KIND_ACC;
        i_bin_index   <= '0;
        i_slot_index  <= '0;
        i_grad_value  <= '0;
        i_hess_value  <= '0;
        i_pass_end    <= 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // written while the table clear sweep runs
        write_slots(6'd4);
        send_sample(mk(KIND_ACC, 8'd0, 6'sd0, VALUE_MAX, VALUE_MIN, 1'b0));
        send_sample(mk(KIND_ACC, 8'd0, 6'sd0, 32'sd1, -32'sd1, 1'b0));
        send_sample(mk(KIND_ACC, 8'd255, 6'sd3, VALUE_MIN, VALUE_MAX, 1'b0));
        send_sample(mk(KIND_ACC, 8'd255, -6'sd1, 32'sd77, 32'sd77, 1'b0));
        send_sample(mk(KIND_READ, 8'd255, -6'sd32, '0, '0, 1'b0));
        send_sample(mk(KIND_ACC, 8'd0, 6'sd4, 32'sd5, 32'sd5, 1'b0));
        send_sample(mk(KIND_READ, 8'd9, 6'sd31, '0, '0, 1'b0));
        send_sample(mk(KIND_READ, 8'd0, 6'sd0, 32'sd12, 32'sd34, 1'b0));
        send_sample(mk(KIND_READ, 8'd0, 6'sd0, '0, '0, 1'b0));
        // back-to-back hits on one entry exercise the write-back forwarding
        send_sample(mk(KIND_ACC, 8'd100, 6'sd2, 32'sh10000, 32'sh8000, 1'b0));
        send_sample(mk(KIND_ACC, 8'd100, 6'sd2, 32'sh10000, 32'sh8000, 1'b0));
        send_sample(mk(KIND_READ, 8'd100, 6'sd2, '0, '0, 1'b0));
        send_sample(mk(KIND_READ, 8'd255, 6'sd3, '0, '0, 1'b1));

        drain_results();
        write_slots(6'd0);
        send_sample(mk(KIND_ACC, 8'd255, 6'sd0, -32'sd1, 32'sd1, 1'b0));
        send_sample(mk(KIND_ACC, 8'd255, 6'sd1, 32'sd9, 32'sd9, 1'b0));
        send_sample(mk(KIND_READ, 8'd255, 6'sd0, '0, '0, 1'b1));

        // run one entry up to large sums at full rate, then read it back
        drain_results();
        write_slots(6'd63);
        idle_on = 1'b0;
        repeat (PUMP_COUNT) send_sample(mk(KIND_ACC, 8'd7, 6'sd0, VALUE_MAX, VALUE_MIN, 1'b0));
        send_sample(mk(KIND_ACC, 8'd7, 6'sd0, -32'sd5, -32'sd5, 1'b0));
        send_sample(mk(KIND_ACC, 8'd7, 6'sd0, 32'sd3, 32'sd5, 1'b0));
        send_sample(mk(KIND_READ, 8'd7, 6'sd0, '0, '0, 1'b1));
        send_sample(mk(KIND_ACC, 8'd255, 6'sd31, 32'sd2, -32'sd2, 1'b0));
        send_sample(mk(KIND_READ, 8'd255, 6'sd31, '0, '0, 1'b1));

        idle_on = 1'b1;
        run_random_phase(6'd1, 115, 1'b0);
        run_random_phase(6'd32, 115, 1'b1);
        run_random_phase(6'd33, 115, 1'b0);
        run_random_phase(SLOT_W'($urandom_range(1, 31)), 115, 1'b0);
        run_random_phase(6'd0, 100, 1'b1);
        run_random_phase(6'd2, 115, 1'b0);
        run_random_phase(SLOT_W'($urandom), 115, 1'b0);
        idle_on = 1'b0;
        run_random_phase(6'd5, 115, 1'b0);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
